[rtl/nd_block_tile_bounds_macros.svh]
// Assertion helpers shared by the tile bounds block.
// Every macro samples on clk and stays quiet while rst is high.
`ifndef ND_BLOCK_TILE_BOUNDS_MACROS_SVH
`define ND_BLOCK_TILE_BOUNDS_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define NDTB_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Condition c must hold in the cycle after a.
`define NDTB_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

[rtl/ndtb_pkg.sv]
package ndtb_pkg;

  localparam int MAX_DIMS_DEF = 7;
  localparam int DIV_W        = 32;
  localparam logic [31:0] TILE_CAP = 32'h8000_0000;

  // Item kinds carried on s_tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  // Configuration register indexes
  localparam logic REG_ARRAY_DIMS = 1'b0;
  localparam logic REG_BLOCK_DIMS = 1'b1;

  typedef enum logic [2:0] {
    OC_OK        = 3'd0,
    OC_NO_TILE   = 3'd1,
    OC_BAD_BDIMS = 3'd2,
    OC_BAD_SIZE  = 3'd3,
    OC_BAD_NUM   = 3'd4
  } outcome_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EXT,
    ST_DIVW,
    ST_MUL,
    ST_CMP,
    ST_DSTART,
    ST_DDIVW,
    ST_DEMIT,
    ST_STAT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/ndtb_div.sv]
module ndtb_div
  import ndtb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] den;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             qbit;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    diff    = shifted - {1'b0, den};
    qbit    = (shifted >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold the working remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], qbit};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

[rtl/nd_block_tile_bounds.sv]
// Tile bounds of an N-dimensional array split into tiles.
// Input stream s_*: s_tuser selects a load beat (store one dimension's lower
// and upper bound and maximum tile size) or a request beat (1-based tile
// number). Output stream m_*: one beat per dimension, highest dimension
// first, m_tlast on dimension 0; a failed check or a tile number past the
// count gives a single status beat with zeroed data and m_tlast set.
// Config port cfg_*: index 0 array_dims, index 1 block_dims; always ready.
// Flow: a load beat is stored without leaving idle. A request runs one shared
// iterative 32-step divider: checks of block_dims first, then one division
// per array dimension to form tile counts and strides, then one division
// per dimension to decode. s_tready is low while a request is in progress.
// Reset sets array_dims and block_dims to 1 and idles the sequencer; the
// descriptor stores are undefined until loaded. A stalled m_tready holds
// the result register and pauses the decode; the next input beat is taken
// while the final result still waits.
module nd_block_tile_bounds
  import ndtb_pkg::*;
#(
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // dim_index[2:0], dim_lower[34:3], dim_upper[66:35], max_tile_size[98:67],
  // block_number[130:99], zero pad
  input  logic [135:0] s_tdata,
  // kind[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_dim[2:0], tile_lower[34:3], tile_upper[66:35], zero pad
  output logic [71:0]  m_tdata,
  // outcome[2:0]
  output logic [2:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [3:0]   cfg_data
);

  `include "nd_block_tile_bounds_macros.svh"

  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW = $clog2(MAX_DIMS + 1);

  // Input fields
  logic [2:0]  in_dim;
  logic [31:0] in_lower, in_upper, in_max, in_bnum;
  assign in_dim   = s_tdata[2:0];
  assign in_lower = s_tdata[34:3];
  assign in_upper = s_tdata[66:35];
  assign in_max   = s_tdata[98:67];
  assign in_bnum  = s_tdata[130:99];

  // Registers
  state_t      state, state_next;
  logic [2:0]  array_dims;
  logic [3:0]  block_dims;
  logic [CW-1:0] cnt;
  logic [CW-1:0] nd;
  logic [31:0] bnum, ibm1, total;
  logic [63:0] prod;
  outcome_t    stat_code;
  logic [31:0] lo_mem     [MAX_DIMS];
  logic [31:0] hi_mem     [MAX_DIMS];
  logic [31:0] ms_mem     [MAX_DIMS];
  logic [31:0] stride_mem [MAX_DIMS];
  logic [31:0] size_mem   [MAX_DIMS];
  logic [2:0]  o_dim;
  logic [31:0] o_lo, o_hi;
  outcome_t    o_code;
  logic        o_last;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  ndtb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic [DW-1:0] idx;
  assign idx = cnt[DW-1:0];

  // Combinational helpers
  logic          accept, load_ok, bd_bad, out_free, cnt_lt_bd, at_bd, at_nd;
  logic [CW-1:0] nd_calc;
  logic signed [33:0] ext_raw, ext_c, ms34;
  logic [31:0]   sz_v, extm1_v;
  logic signed [34:0] lo35, hi35, up35;

  always_comb begin
    accept    = s_tvalid && s_tready;
    load_ok   = (32'(in_dim) < MAX_DIMS);
    bd_bad    = (block_dims == 4'd0) || (32'(block_dims) > MAX_DIMS);
    out_free  = !m_tvalid || m_tready;
    cnt_lt_bd = (32'(cnt) < 32'(block_dims));
    at_bd     = (32'(cnt) == 32'(block_dims));
    at_nd     = (cnt == nd);
    if (array_dims == 3'd0)
      nd_calc = CW'(1);
    else if (32'(array_dims) > MAX_DIMS)
      nd_calc = CW'(MAX_DIMS);
    else
      nd_calc = CW'(array_dims);

    // Extent and capped tile size of the current dimension
    ext_raw = {{2{hi_mem[idx][31]}}, hi_mem[idx]} - {{2{lo_mem[idx][31]}}, lo_mem[idx]}
              + 34'sd1;
    ext_c   = (ext_raw < 34'sd1) ? 34'sd1 : ext_raw;
    ms34    = {{2{ms_mem[idx][31]}}, ms_mem[idx]};
    extm1_v = 32'(ext_c - 34'sd1);
    if (!cnt_lt_bd)
      sz_v = 32'd1;
    else if (ms34 < ext_c)
      sz_v = ms_mem[idx];
    else
      sz_v = ext_c[31:0];

    // Tile bounds of the current dimension
    lo35 = {{3{lo_mem[idx][31]}}, lo_mem[idx]} + {3'b000, prod[31:0]};
    hi35 = lo35 + {3'b000, size_mem[idx]} - 35'sd1;
    up35 = {{3{hi_mem[idx][31]}}, hi_mem[idx]};
  end

  // Next state and divider control
  always_comb begin
    state_next  = state;
    div_req     = '0;
    s_tready    = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser[0] == KIND_REQ)
          state_next = bd_bad ? ST_STAT : ST_CHECK;
      end
      ST_CHECK: begin
        if (at_bd)
          state_next = ($signed(bnum) < 32'sd1) ? ST_STAT : ST_EXT;
        else if ($signed(ms_mem[idx]) < 32'sd1)
          state_next = ST_STAT;
      end
      ST_EXT: begin
        if (at_nd) begin
          state_next = ST_CMP;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = extm1_v;
          div_req.den   = sz_v;
          state_next    = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (div_rsp.done)
          state_next = div_rsp.quo[31] ? ST_EXT : ST_MUL;
      end
      ST_MUL:    state_next = ST_EXT;
      ST_CMP:    state_next = (bnum > total) ? ST_STAT : ST_DSTART;
      ST_DSTART: begin
        div_req.start = 1'b1;
        div_req.num   = ibm1;
        div_req.den   = stride_mem[idx];
        state_next    = ST_DDIVW;
      end
      ST_DDIVW: begin
        if (div_rsp.done)
          state_next = ST_DEMIT;
      end
      ST_DEMIT: begin
        if (out_free)
          state_next = (cnt == '0) ? ST_IDLE : ST_DSTART;
      end
      ST_STAT: begin
        if (out_free)
          state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= ST_IDLE;
    else
      state <= state_next;
  end

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      array_dims <= 3'd1;
      block_dims <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index[0])
        REG_ARRAY_DIMS: array_dims <= cfg_data[2:0];
        default:        block_dims <= cfg_data;
      endcase
    end
  end

  // Descriptor stores
  always_ff @(posedge clk) begin
    if (accept && s_tuser[0] == KIND_LOAD && load_ok) begin
      lo_mem[DW'(in_dim)] <= in_lower;
      hi_mem[DW'(in_dim)] <= in_upper;
      ms_mem[DW'(in_dim)] <= in_max;
    end
    if (state == ST_EXT && !at_nd) begin
      stride_mem[idx] <= total;
      size_mem[idx]   <= sz_v;
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        bnum      <= in_bnum;
        cnt       <= '0;
        stat_code <= OC_BAD_BDIMS;
      end
      ST_CHECK: begin
        if (at_bd) begin
          nd        <= nd_calc;
          cnt       <= '0;
          total     <= 32'd1;
          stat_code <= OC_BAD_NUM;
        end else begin
          cnt       <= cnt + CW'(1);
          stat_code <= OC_BAD_SIZE;
        end
      end
      ST_DIVW: begin
        if (div_rsp.done) begin
          if (div_rsp.quo[31]) begin
            total <= TILE_CAP;
            cnt   <= cnt + CW'(1);
          end else begin
            prod <= total * (div_rsp.quo + 32'd1);
          end
        end
      end
      ST_MUL: begin
        total <= (prod > {32'd0, TILE_CAP}) ? TILE_CAP : prod[31:0];
        cnt   <= cnt + CW'(1);
      end
      ST_CMP: begin
        ibm1      <= bnum - 32'd1;
        cnt       <= nd - CW'(1);
        stat_code <= OC_NO_TILE;
      end
      ST_DDIVW: begin
        if (div_rsp.done) begin
          prod <= div_rsp.quo * size_mem[idx];
          ibm1 <= div_rsp.rem;
        end
      end
      ST_DEMIT: begin
        if (out_free && cnt != '0)
          cnt <= cnt - CW'(1);
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DEMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (state == ST_STAT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DEMIT && out_free) begin
      o_dim  <= 3'(cnt);
      o_lo   <= lo35[31:0];
      o_hi   <= (hi35 > up35) ? hi_mem[idx] : hi35[31:0];
      o_code <= OC_OK;
      o_last <= (cnt == '0);
    end else if (state == ST_STAT && out_free) begin
      o_dim  <= 3'd0;
      o_lo   <= 32'd0;
      o_hi   <= 32'd0;
      o_code <= stat_code;
      o_last <= 1'b1;
    end
  end

  assign m_tdata = {5'd0, o_hi, o_lo, o_dim};
  assign m_tuser = o_code;
  assign m_tlast = o_last;

  `NDTB_ASSERT_IMP(a_stat_shape, m_tvalid && o_code != OC_OK, o_last && m_tdata == 72'd0, "status beat must be last with zero data")
  `NDTB_ASSERT_IMP(a_idle_div, s_tready, !div_rsp.busy, "divider busy while accepting input")
  `NDTB_ASSERT_IMP(a_done_wait, div_rsp.done, state == ST_DIVW || state == ST_DDIVW, "divider result with nobody waiting")
  `NDTB_ASSERT_NXT(a_start_busy, div_req.start, div_rsp.busy, "divider did not start")

endmodule

[bench/tb_nd_block_tile_bounds.sv]
`timescale 1ns / 1ps

module tb_nd_block_tile_bounds
  import ndtb_pkg::*;
();

  localparam int NDIM = MAX_DIMS_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  dim;
    logic [31:0] lo;
    logic [31:0] hi;
    outcome_t    oc;
    logic        last;
  } tile_beat_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic [0:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [71:0]  m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [0:0]   cfg_index;
  logic [3:0]   cfg_data;

  // predictor state
  logic [2:0]  arr_dims_q;
  logic [3:0]  blk_dims_q;
  logic [31:0] lo_store [NDIM];
  logic [31:0] hi_store [NDIM];
  logic [31:0] sz_store [NDIM];

  tile_beat_t  tile_q [$];
  int          errors;
  int          n_req;
  int          n_load;
  int          n_beats;
  int          idle_cnt;
  bit          rx_idle_en;
  bit          tx_idle_en;
  bit          hold_rx;

  nd_block_tile_bounds dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // push one status beat
  task automatic push_status(input outcome_t oc);
    tile_beat_t b;
    b = '{dim: 3'd0, lo: 32'd0, hi: 32'd0, oc: oc, last: 1'b1};
    tile_q.push_back(b);
  endtask

  // compute the expected beats of one tile request
  task automatic predict_tile(input logic [31:0] bnum_raw);
    longint bnum, ext, sz, total, blk, lo, hi, ib;
    longint stride [NDIM];
    longint size [NDIM];
    int nd;
    tile_beat_t b;
    if (blk_dims_q < 1 || blk_dims_q > NDIM) begin
      push_status(OC_BAD_BDIMS);
      return;
    end
    for (int i = 0; i < blk_dims_q; i++)
      if ($signed(sz_store[i]) < 1) begin
        push_status(OC_BAD_SIZE);
        return;
      end
    bnum = $signed(bnum_raw);
    if (bnum < 1) begin
      push_status(OC_BAD_NUM);
      return;
    end
    nd = (arr_dims_q < 1) ? 1 : (arr_dims_q > NDIM ? NDIM : arr_dims_q);
    total = 1;
    for (int i = 0; i < nd; i++) begin
      longint nblk;
      ext = longint'($signed(hi_store[i])) - longint'($signed(lo_store[i])) + 1;
      if (ext < 1) ext = 1;
      stride[i] = total;
      if (i < blk_dims_q) sz = ($signed(sz_store[i]) < ext) ? $signed(sz_store[i]) : ext;
      else sz = 1;
      size[i] = sz;
      nblk = (ext - 1) / sz + 1;
      if (nblk > longint'(TILE_CAP) / total) total = TILE_CAP;
      else total = total * nblk;
      if (total > longint'(TILE_CAP)) total = TILE_CAP;
    end
    if (bnum > total) begin
      push_status(OC_NO_TILE);
      return;
    end
    ib = bnum;
    for (int d = nd - 1; d >= 0; d--) begin
      blk = (ib - 1) / stride[d];
      lo = longint'($signed(lo_store[d])) + blk * size[d];
      hi = lo + size[d] - 1;
      if (hi > longint'($signed(hi_store[d]))) hi = $signed(hi_store[d]);
      ib -= blk * stride[d];
      b = '{dim: d[2:0], lo: lo[31:0], hi: hi[31:0], oc: OC_OK, last: (d == 0)};
      tile_q.push_back(b);
    end
  endtask

  // random idle burst on the sender side
  task automatic tx_gap();
    if (tx_idle_en && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 8)) @(negedge clk);
  endtask

  // send one beat and update the predictor on acceptance
  task automatic send_beat(input logic kind, input logic [2:0] di, input logic [31:0] lo,
                           input logic [31:0] hi, input logic [31:0] ms,
                           input logic [31:0] bn);
    tx_gap();
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {5'd0, bn, ms, hi, lo, di};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == KIND_LOAD) begin
      n_load++;
      if (di < NDIM) begin
        lo_store[di] = lo;
        hi_store[di] = hi;
        sz_store[di] = ms;
      end
    end else begin
      n_req++;
      predict_tile(bn);
    end
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic load_dim(input int d, input int lo, input int hi, input int ms);
    send_beat(KIND_LOAD, d[2:0], lo, hi, ms, $urandom);
  endtask

  task automatic request(input int bn);
    send_beat(KIND_REQ, 3'($urandom), $urandom, $urandom, $urandom, bn);
  endtask

  // wait until every expected beat has come, then let the block settle
  task automatic drain();
    while (tile_q.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ARRAY_DIMS) arr_dims_q = val[2:0];
    else blk_dims_q = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_dims(input int ad, input int bd);
    drain();
    write_reg(REG_ARRAY_DIMS, ad[3:0]);
    write_reg(REG_BLOCK_DIMS, bd[3:0]);
  endtask

  task automatic load_all_small();
    for (int d = 0; d < NDIM; d++)
      load_dim(d, $urandom_range(0, 20) - 10, $urandom_range(0, 30) - 10,
               $urandom_range(1, 6));
  endtask

  // extremes, every outcome and the special cases
  task automatic test_directed();
    load_dim(0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    request(1);
    request(2);
    request(3);
    request(0);
    request(32'h8000_0000);
    request(32'h7fff_ffff);
    load_dim(0, 5, 2, 3);
    request(1);
    load_dim(0, 0, 9, 0);
    request(1);
    load_dim(0, 0, 9, 32'h8000_0000);
    request(1);
    load_dim(7, 1, 2, 3);
    load_dim(0, 0, 9, 4);
    request(3);
    request(4);
    load_all_small();
    for (int d = 0; d < NDIM; d++)
      load_dim(d, 32'h8000_0000 + d, 32'h7fff_fff0, 32'h0000_0003);
    set_dims(7, 7);
    request(1);
    request(32'h7fff_ffff);
    set_dims(0, 0);
    request(1);
    set_dims(7, 8);
    request(1);
    set_dims(7, 15);
    request(1);
    set_dims(5, 2);
    request(5);
  endtask

  task automatic rand_request(input int nd);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) request($urandom);
    else if (r == 1) request(-$urandom_range(0, 5));
    else request($urandom_range(1, 40 * nd));
  endtask

  // random phases across several register settings
  task automatic test_random(input int n);
    int ad, bd;
    for (int ph = 0; ph < 10; ph++) begin
      ad = $urandom_range(0, 7);
      bd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 7);
      set_dims(ad, bd);
      load_all_small();
      for (int k = 0; k < n / 10; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          int d;
          d = $urandom_range(0, 7);
          if ($urandom_range(0, 4) == 0)
            load_dim(d, $urandom, $urandom, $urandom);
          else
            load_dim(d, $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 15,
                     $urandom_range(0, 8));
        end else begin
          rand_request(ad);
        end
      end
    end
  endtask

  // receiver holds off while requests keep arriving
  task automatic test_backpressure();
    set_dims(3, 3);
    load_all_small();
    hold_rx = 1'b1;
    fork
      begin
        repeat (2000) @(negedge clk);
        hold_rx = 1'b0;
      end
      for (int k = 0; k < 8; k++) request($urandom_range(1, 20));
    join
    drain();
  endtask

  // ready driver
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) m_tready <= 1'b0;
      else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else m_tready <= 1'b1;
    end
  end

  // compare each output beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tile_beat_t e;
      if (tile_q.size() == 0) begin
        $display("%0t: unexpected beat dim=%0d lo=%h hi=%h oc=%0d last=%b", $time,
                 m_tdata[2:0], m_tdata[34:3], m_tdata[66:35], m_tuser, m_tlast);
        errors++;
      end else begin
        e = tile_q.pop_front();
        n_beats++;
        if (m_tdata[2:0] !== e.dim || m_tdata[34:3] !== e.lo ||
            m_tdata[66:35] !== e.hi || m_tuser !== e.oc || m_tlast !== e.last ||
            m_tdata[71:67] !== 5'd0) begin
          $display("%0t: mismatch expected dim=%0d lo=%h hi=%h oc=%0d last=%b", $time,
                   e.dim, e.lo, e.hi, e.oc, e.last);
          $display("%0t:          actual   dim=%0d lo=%h hi=%h oc=%0d last=%b", $time,
                   m_tdata[2:0], m_tdata[34:3], m_tdata[66:35], m_tuser, m_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_valid)
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_LOAD;
    cfg_valid = 1'b0;
    cfg_index = REG_ARRAY_DIMS;
    cfg_data = '0;
    errors = 0;
    n_req = 0;
    n_load = 0;
    n_beats = 0;
    idle_cnt = 0;
    hold_rx = 1'b0;
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
    arr_dims_q = 3'd1;
    blk_dims_q = 4'd1;
    for (int d = 0; d < NDIM; d++) begin
      lo_store[d] = '0;
      hi_store[d] = '0;
      sz_store[d] = '0;
    end
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(300);
    test_backpressure();
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random(60);
    drain();
    $display("Covered %0d loads and %0d tile requests, %0d result beats checked.",
             n_load, n_req, n_beats);
    if (errors == 0 && tile_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
